// ===== design/positional_array_list_defines.svh =====
// ----------------------------------------------------------------------------
// Positional array list assertion macros
// Shared property wrappers for the list block checks.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PAL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Types and constants shared by the positional array list cells and top level.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;
  localparam int CNT_W     = 5;
  localparam int CAP_W     = 5;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  typedef enum logic [MODE_W-1:0] {
    MODE_GET    = 3'd0,
    MODE_SET    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

// ===== design/pal_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell
// One list entry: overwrite, take the left neighbor on insert, take the right
// neighbor on delete, and add its word to the read chain when selected.
// ----------------------------------------------------------------------------
module pal_cell (
  input  logic                      clk,
  input  pal_pkg::cell_cmd_t        cmd,
  input  logic [pal_pkg::IDX_W-1:0] cell_idx,
  input  logic [pal_pkg::WORD_W-1:0] left_data,
  input  logic [pal_pkg::WORD_W-1:0] right_data,
  input  logic [pal_pkg::WORD_W-1:0] rd_in,
  output logic [pal_pkg::WORD_W-1:0] data,
  output logic [pal_pkg::WORD_W-1:0] rd_out
);
  import pal_pkg::*;

  logic [WORD_W-1:0] data_next;
  logic              hit;

  assign hit    = (cell_idx == cmd.idx);
  assign rd_out = rd_in | (hit ? data : '0);

  always_comb begin
    data_next = data;
    case (cmd.op)
      OP_SET: begin
        if (hit) data_next = cmd.word;
      end
      OP_INSERT: begin
        if (hit) data_next = cmd.word;
        else if (cell_idx > cmd.idx) data_next = left_data;
      end
      OP_DELETE: begin
        if (cell_idx >= cmd.idx) data_next = right_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== design/pal_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_row
// Row of list cells linked to their neighbors, with an OR chain for reads.
// ----------------------------------------------------------------------------
module pal_row (
  input  logic                       clk,
  input  pal_pkg::cell_cmd_t         cmd,
  output logic [pal_pkg::WORD_W-1:0] rd_data
);
  import pal_pkg::*;

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] rd_chain  [DEPTH+1];

  assign rd_chain[0] = '0;
  assign rd_data     = rd_chain[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    pal_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (IDX_W'(i)),
      .left_data  (left_w),
      .right_data (right_w),
      .rd_in      (rd_chain[i]),
      .data       (cell_data[i]),
      .rd_out     (rd_chain[i+1])
    );
  end

endmodule

// ===== design/positional_array_list.sv =====
`timescale 1ns / 1ps
`include "positional_array_list_defines.svh"
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded list of 32-bit words by 1-based position: get, set, insert, delete
// and clear, one result per operation, built on a row of shifting cells.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   40     mode, position, new_value
// m_axis    out  48     read_value, status, count, is_full, is_empty
// cfg       in   5      capacity
//
// Each operation is applied at its accepting edge: all cells shift or load
// together, and the result lands in the output register.
// One operation per cycle is sustained while m_axis_tready stays high; a held
// result stalls input only when a new one would overwrite it.
// Synchronous reset empties the list and sets capacity to 10; no clearing
// pass is needed since entries past the count are never read.
// ----------------------------------------------------------------------------
module positional_array_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [2:0] mode, [7:3] position, [39:8] new_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [31:0] read_value, [33:32] status,
                                     // [38:34] count, [39] is_full,
                                     // [40] is_empty, [47:41] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data       // [4:0] capacity
);
  import pal_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CAP_W-1:0]  capacity;
  logic [CAP_W-1:0]  cap_eff;
  logic              accept;

  mode_t             mode;
  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] word;
  logic              pos_ok;
  logic              ins_pos_ok;
  logic              full_now;
  logic              rd_sel;
  status_t           status;
  cell_op_t          op;
  cell_cmd_t         cmd;
  logic [WORD_W-1:0] row_rd;
  logic [WORD_W-1:0] read_value;

  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;

  assign mode = mode_t'(s_axis_tdata[2:0]);
  assign pos  = s_axis_tdata[7:3];
  assign word = s_axis_tdata[39:8];

  assign cap_eff    = (capacity > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity;
  assign full_now   = (count >= CNT_W'(cap_eff));
  assign pos_ok     = (pos != '0) && (pos <= POS_W'(count));
  assign ins_pos_ok = (pos != '0) &&
                      ({1'b0, pos} <= ({1'b0, POS_W'(count)} + (POS_W+1)'(1)));

  always_comb begin
    status     = ST_OK;
    op         = OP_HOLD;
    rd_sel     = 1'b0;
    count_next = count;
    unique case (mode)
      MODE_GET: begin
        if (!pos_ok) status = ST_RANGE;
        else rd_sel = 1'b1;
      end
      MODE_SET: begin
        if (!pos_ok) status = ST_RANGE;
        else op = OP_SET;
      end
      MODE_INSERT: begin
        if (!ins_pos_ok) begin
          status = ST_RANGE;
        end else if (full_now) begin
          status = ST_FULL;
        end else begin
          op         = OP_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          op         = OP_DELETE;
          rd_sel     = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      MODE_CLEAR: begin
        count_next = '0;
      end
      default: ;
    endcase
  end

  // Cells only move on an accepted transfer
  assign cmd.op   = accept ? op : OP_HOLD;
  assign cmd.idx  = IDX_W'(pos - POS_W'(1));
  assign cmd.word = word;

  pal_row u_row (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (row_rd)
  );

  assign read_value = rd_sel ? row_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (accept) count <= count_next;
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {7'b0,
                       (count_next == '0),
                       (count_next >= CNT_W'(cap_eff)),
                       count_next,
                       status,
                       read_value};
    end
  end

  `PAL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count above depth")
  `PAL_ASSERT_NEXT(a_accept_valid, clk, rst, accept, m_axis_tvalid, "accepted item gave no result")
  `PAL_ASSERT_NEXT(a_insert_grows, clk, rst, accept && (cmd.op == OP_INSERT), count == $past(count) + CNT_W'(1), "insert did not grow count")
  `PAL_ASSERT_NOW(a_empty_flag, clk, rst, m_axis_tvalid, m_axis_tdata[40] == (m_axis_tdata[38:34] == '0), "empty flag disagrees with count")

endmodule

// ===== bench/positional_array_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_tb
// Drives list operations over the input stream and checks every result against
// a cycle-free model of the list kept in the bench or a given directed result.
// A short table of directed operations comes first, then random phases with
// capacity changes, idle gaps on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module positional_array_list_tb;
  import pal_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam int SEGMENTS       = 12;
  localparam int SEG_ITEMS      = 50;
  localparam int RX_HOLD_CYCLES = 120;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic              is_full;
    logic              is_empty;
  } list_result_t;

  typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;   // capacity in the low bits for ROW_CAP
    logic              has_golden;
    list_result_t      golden;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [2:0] mode, [7:3] position, [39:8] new_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [31:0] read_value, [33:32] status, [38:34] count,
                                    // [39] is_full, [40] is_empty, [47:41] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;       // [4:0] capacity

  // Model of the list, updated on every accepted transfer
  logic [WORD_W-1:0] list_words [DEPTH];
  logic [CNT_W-1:0]  list_len = '0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;
  list_result_t      result_q [$];

  logic         item_has_golden = 1'b0;
  list_result_t item_golden = '0;
  int           error_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_requests = 0;
  plan_row_t    directed_plan [$];

  positional_array_list u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic list_result_t apply_list_op(logic [MODE_W-1:0] op,
                                                 logic [POS_W-1:0] pos,
                                                 logic [WORD_W-1:0] word);
    list_result_t r;
    int eff;
    int n;
    int p;
    int i;
    eff = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    n = list_len;
    p = pos;
    r = '0;
    r.status = ST_OK;
    case (op)
      MODE_GET: begin
        if (p < 1 || p > n) r.status = ST_RANGE;
        else r.read_value = list_words[p-1];
      end
      MODE_SET: begin
        if (p < 1 || p > n) r.status = ST_RANGE;
        else list_words[p-1] = word;
      end
      MODE_INSERT: begin
        // position is checked before fullness
        if (p < 1 || p > n + 1) begin
          r.status = ST_RANGE;
        end else if (n >= eff) begin
          r.status = ST_FULL;
        end else begin
          for (i = n; i > p - 1; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = word;
          n++;
        end
      end
      MODE_DELETE: begin
        if (p < 1 || p > n) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_words[p-1];
          for (i = p - 1; i + 1 < n; i++) list_words[i] = list_words[i+1];
          n--;
        end
      end
      MODE_CLEAR: n = 0;
      default: ;
    endcase
    list_len = n[CNT_W-1:0];
    r.count = n[CNT_W-1:0];
    r.is_full = (n >= eff);
    r.is_empty = (n == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // Sample both streams and the config channel at the rising edge
  always @(posedge clk) begin : stream_monitor
    list_result_t seen;
    list_result_t want;
    list_result_t predicted;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.read_value = m_axis_tdata[31:0];
        seen.status     = status_t'(m_axis_tdata[33:32]);
        seen.count      = m_axis_tdata[38:34];
        seen.is_full    = m_axis_tdata[39];
        seen.is_empty   = m_axis_tdata[40];
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected: tdata %0h", m_axis_tdata);
          error_count++;
        end else begin
          want = result_q.pop_front();
          check_field("read_value", want.read_value, seen.read_value);
          check_field("status", want.status, seen.status);
          check_field("count", want.count, seen.count);
          check_field("is_full", want.is_full, seen.is_full);
          check_field("is_empty", want.is_empty, seen.is_empty);
          check_field("pad", '0, m_axis_tdata[47:41]);
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = apply_list_op(s_axis_tdata[2:0], s_axis_tdata[7:3], s_axis_tdata[39:8]);
        result_q.push_back(item_has_golden ? item_golden : predicted);
      end
    end
  end

  // Receiver ready: random idling, plus a long hold-off on request
  initial begin : rx_ready_gen
    int stall_left;
    int served;
    stall_left = 0;
    served = 0;
    forever begin
      @(negedge clk);
      if (served != hold_requests) begin
        served = hold_requests;
        stall_left = RX_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic list_result_t res(logic [WORD_W-1:0] rd, status_t st,
                                       logic [CNT_W-1:0] cnt, logic full, logic empty);
    list_result_t r;
    r.read_value = rd;
    r.status = st;
    r.count = cnt;
    r.is_full = full;
    r.is_empty = empty;
    return r;
  endfunction

  function automatic void add_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                 logic [WORD_W-1:0] word, logic has_golden,
                                 list_result_t golden);
    directed_plan.push_back('{ROW_OP, mode, pos, word, has_golden, golden});
  endfunction

  function automatic void add_cap(logic [CAP_W-1:0] cap);
    directed_plan.push_back('{ROW_CAP, '0, '0, WORD_W'(cap), 1'b0, '0});
  endfunction

  // Called and returning at a falling edge
  task automatic send_item(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                           logic [WORD_W-1:0] word, logic has_golden,
                           list_result_t golden);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= {word, pos, mode};
    item_has_golden <= has_golden;
    item_golden     <= golden;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_op(int ins_pct);
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) mode = MODE_INSERT;
    else begin
      r = $urandom_range(99);
      if (r < 35) mode = MODE_DELETE;
      else if (r < 65) mode = MODE_GET;
      else if (r < 90) mode = MODE_SET;
      else if (r < 93) mode = MODE_CLEAR;
      else mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    end
    // mostly legal positions so the list fills and shifts; some noise
    if ($urandom_range(99) < 12) pos = POS_W'($urandom_range(0, 31));
    else if (mode == MODE_INSERT) pos = POS_W'($urandom_range(1, list_len + 1));
    else if (list_len == 0) pos = POS_W'($urandom_range(0, 2));
    else pos = POS_W'($urandom_range(1, list_len));
    case ($urandom_range(9))
      0: word = 32'h7FFF_FFFF;
      1: word = 32'h8000_0000;
      2: word = ($urandom_range(1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: word = $urandom;
    endcase
    send_item(mode, pos, word, 1'b0, '0);
  endtask

  initial begin : stimulus
    int seg_caps [SEGMENTS];
    int cap;
    int ins_pct;
    seg_caps = '{16, 31, 4, 1, 0, 10, 2, 16, 7, 31, -1, 15};

    // Directed: empty list, extremes, every operation, full and capacity cases
    add_op(MODE_GET,    5'd1,  32'h0,         1'b1, res(32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1));
    add_op(MODE_DELETE, 5'd0,  32'h0,         1'b1, res(32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1));
    add_op(MODE_INSERT, 5'd0,  32'h1,         1'b1, res(32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1));
    add_op(MODE_INSERT, 5'd2,  32'h1,         1'b1, res(32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1));
    add_op(MODE_INSERT, 5'd1,  32'h7FFF_FFFF, 1'b1, res(32'h0, ST_OK, 5'd1, 1'b0, 1'b0));
    add_op(MODE_INSERT, 5'd1,  32'h8000_0000, 1'b1, res(32'h0, ST_OK, 5'd2, 1'b0, 1'b0));
    add_op(MODE_INSERT, 5'd3,  32'h0,         1'b0, '0);
    add_op(MODE_INSERT, 5'd2,  32'hFFFF_FFFF, 1'b0, '0);
    add_op(MODE_GET,    5'd1,  32'h0,         1'b1,
           res(32'h8000_0000, ST_OK, 5'd4, 1'b0, 1'b0));
    add_op(MODE_GET,    5'd4,  32'h0,         1'b0, '0);
    add_op(MODE_GET,    5'd5,  32'h0,         1'b1, res(32'h0, ST_RANGE, 5'd4, 1'b0, 1'b0));
    add_op(MODE_SET,    5'd4,  32'h1234_5678, 1'b1, res(32'h0, ST_OK, 5'd4, 1'b0, 1'b0));
    add_op(MODE_SET,    5'd31, 32'hDEAD_BEEF, 1'b1, res(32'h0, ST_RANGE, 5'd4, 1'b0, 1'b0));
    add_op(MODE_GET,    5'd4,  32'h0,         1'b0, '0);
    add_op(MODE_DELETE, 5'd2,  32'h0,         1'b0, '0);
    add_op(MODE_GET,    5'd2,  32'h0,         1'b0, '0);
    add_op(MODE_SPARE_FIRST, 5'd17, 32'hFFFF_FFFF, 1'b1,
           res(32'h0, ST_OK, 5'd3, 1'b0, 1'b0));
    add_op(MODE_SPARE_LAST,  5'd1,  32'h5555_AAAA, 1'b1,
           res(32'h0, ST_OK, 5'd3, 1'b0, 1'b0));
    add_op(MODE_CLEAR,  5'd9,  32'hAAAA_5555, 1'b1, res(32'h0, ST_OK, 5'd0, 1'b0, 1'b1));
    add_op(MODE_DELETE, 5'd1,  32'h0,         1'b1, res(32'h0, ST_RANGE, 5'd0, 1'b0, 1'b1));
    add_cap(5'd1);
    add_op(MODE_INSERT, 5'd1,  32'h5,         1'b1, res(32'h0, ST_OK, 5'd1, 1'b1, 1'b0));
    add_op(MODE_INSERT, 5'd1,  32'h6,         1'b1, res(32'h0, ST_FULL, 5'd1, 1'b1, 1'b0));
    add_op(MODE_INSERT, 5'd3,  32'h6,         1'b1, res(32'h0, ST_RANGE, 5'd1, 1'b1, 1'b0));
    // capacity zero counts as full, even when empty
    add_cap(5'd0);
    add_op(MODE_DELETE, 5'd1,  32'h0,         1'b1, res(32'h5, ST_OK, 5'd0, 1'b1, 1'b1));
    add_op(MODE_INSERT, 5'd1,  32'h7,         1'b1, res(32'h0, ST_FULL, 5'd0, 1'b1, 1'b1));

    tx_idle_pct = 18;
    rx_idle_pct <= 85;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CAP) set_capacity(directed_plan[i].word[CAP_W-1:0]);
      else send_item(directed_plan[i].mode, directed_plan[i].pos, directed_plan[i].word,
                     directed_plan[i].has_golden, directed_plan[i].golden);
    end

    // Random phases; each starts with an idle capacity write
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 4) begin
        tx_idle_pct = 85;
        rx_idle_pct <= 18;
      end else if (seg == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      cap = (seg_caps[seg] < 0) ? $urandom_range(0, 31) : seg_caps[seg];
      set_capacity(CAP_W'(cap));
      // lean on inserts when the list may grow long
      ins_pct = (cap >= 12) ? 55 : 32;
      // hold the receiver off while the sender keeps offering
      if (seg == 8) hold_requests <= hold_requests + 1;
      for (int k = 0; k < SEG_ITEMS; k++) send_random_op(ins_pct);
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (error_count == 0) begin
      $display("positional_array_list verification clean");
    end else begin
      $display("positional_array_list verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("positional_array_list verification failed");
    $finish;
  end

endmodule
